// File: src/murmur_hash_64_defines.svh
// Assertion macros for the murmur_hash_64 block.
// Has no dependencies; included by files that carry concurrent assertions.
`ifndef MURMUR_HASH_64_DEFINES_SVH
`define MURMUR_HASH_64_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define MHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mhm_pkg.sv
// Shared constants and types for the murmur_hash_64 block.
// No dependencies; imported by mhm_mul and murmur_hash_64.
package mhm_pkg;

	localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT = 47;

	localparam int unsigned SEED_W = 32;
	localparam int unsigned LEN_W  = 9;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned IDX_W  = 1;

	localparam logic [IDX_W-1:0] REG_HASH_SEED  = 1'd0;
	localparam logic [IDX_W-1:0] REG_KEY_LENGTH = 1'd1;

	typedef struct packed {
		logic        go;
		logic [63:0] operand;
	} mul_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} mul_resp_t;

endpackage

// File: src/mhm_mul.sv
// Multi-cycle 64-bit multiply by the mixing constant, modulo 2^64.
// Uses mhm_pkg; one 32x32 multiplier serves three partial products.
module mhm_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mhm_pkg::mul_req_t  req,
	output mhm_pkg::mul_resp_t resp
);
	import mhm_pkg::*;

	localparam logic [31:0] M_LO = MIX_MULT[31:0];
	localparam logic [31:0] M_HI = MIX_MULT[63:32];

	logic        busy_q;
	logic        done_q;
	logic [1:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [63:0] prod_s1;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// Partial products: lo*lo in full, then the low halves of the two cross terms.
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = a_q[31:0];
				op_b = M_LO;
			end
			2'd1: begin
				op_a = a_q[63:32];
				op_b = M_LO;
			end
			default: begin
				op_a = a_q[31:0];
				op_b = M_HI;
			end
		endcase
		prod = {32'd0, op_a} * {32'd0, op_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.operand;
		end else if (busy_q) begin
			prod_s1 <= prod;
			case (cnt_q)
				2'd1: acc_q <= prod_s1;
				2'd2,
				2'd3: acc_q[63:32] <= acc_q[63:32] + prod_s1[31:0];
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign resp.busy   = busy_q;
	assign resp.done   = done_q;
	assign resp.result = acc_q;

endmodule

// File: src/murmur_hash_64.sv
// murmur_hash_64: MurmurHash2-64A over keys of key_length bytes, one 64-bit word per transfer.
// Every multiply runs on the shared mhm_mul unit.
// A full word costs three multiplies, a tail word one; the first word of a key adds one (seed
// load) and the last word one (finish). The next word is taken only once the sequencer is back
// in idle; after a last word that waits until the hash is loaded into a free output register.
// key_ready is high only while idle; arst_n clears seed, length, count, sequencer, output valid.
module murmur_hash_64 #(
	parameter int unsigned MAX_KEY_BYTES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mhm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [mhm_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        key_valid,
	output logic                        key_ready,
	input  logic [63:0]                 key_word,
	output logic                        hash_valid,
	input  logic                        hash_ready,
	output logic [63:0]                 hash_value
);
	import mhm_pkg::*;

	`include "murmur_hash_64_defines.svh"

	// Lengths above the register's range never saturate, so clamp the limit to it.
	localparam int unsigned LEN_SAT = (MAX_KEY_BYTES > 511) ? 511 : MAX_KEY_BYTES;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_SAT[LEN_W-1:0];
	// Word counter only ever holds positions below the number of words per key.
	localparam int unsigned CNT_W = $clog2((LEN_SAT + 7) / 8 + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_K1,
		S_K2,
		S_HMUL,
		S_TAIL,
		S_FIN,
		S_OUT
	} state_t;

	// Configuration registers
	logic [SEED_W-1:0] seed_q;
	logic [LEN_W-1:0]  klen_q;

	// Sequencer and running state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [63:0]       h_q, h_d;
	logic [63:0]       word_q;
	logic              full_q, tmix_q, last_q;
	logic [2:0]        tail_q;

	// Shared multiplier
	mul_req_t          mul_req;
	logic              mul_go_q;
	logic [63:0]       mul_opnd_q;
	mul_resp_t         mul_resp;
	logic              mul_go;
	logic [63:0]       mul_opnd;

	// Output register
	logic              hash_valid_q;
	logic [63:0]       hash_value_q;
	logic              out_load;

	// Decode of the incoming word's place in the key
	logic [LEN_W-1:0]  len_eff;
	logic [2:0]        tail_w;
	logic [7:0]        pos_w, full_words, total_w;
	logic              acc_full, acc_tmix, acc_last;
	logic              full_sel, tmix_sel, last_sel;
	logic [2:0]        tail_sel;
	logic [63:0]       word_sel, tail_mask;
	logic              key_xfer;

	// Merge points of the sequencer
	logic              do_mix, do_post;
	logic [63:0]       mix_h, post_h, res, res_x;

	assign key_ready = (state_q == S_IDLE);
	assign key_xfer  = key_valid && key_ready;

	assign res   = mul_resp.result;
	assign res_x = res ^ (res >> MIX_SHIFT);

	always_comb begin
		len_eff    = (klen_q > LEN_MAX) ? LEN_MAX : klen_q;
		tail_w     = len_eff[2:0];
		full_words = 8'(len_eff[LEN_W-1:3]);
		total_w    = full_words + 8'(tail_w != 3'd0);
		if (total_w == 8'd0) begin
			total_w = 8'd1;
		end
		pos_w    = 8'(cnt_q);
		acc_full = pos_w < full_words;
		acc_tmix = !acc_full && (tail_w != 3'd0);
		acc_last = (pos_w + 8'd1) >= total_w;

		// Take flags straight from the decode in the transfer cycle, held copies after.
		full_sel  = key_ready ? acc_full : full_q;
		tmix_sel  = key_ready ? acc_tmix : tmix_q;
		last_sel  = key_ready ? acc_last : last_q;
		tail_sel  = key_ready ? tail_w   : tail_q;
		word_sel  = key_ready ? key_word : word_q;
		tail_mask = (64'd1 << {tail_sel, 3'b000}) - 64'd1;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		h_d      = h_q;
		mul_go   = 1'b0;
		mul_opnd = mul_opnd_q;
		out_load = 1'b0;
		do_mix   = 1'b0;
		mix_h    = h_q;
		do_post  = 1'b0;
		post_h   = h_q;

		case (state_q)
			S_IDLE: begin
				if (key_valid) begin
					if (cnt_q == '0) begin
						// Key start: load seed xor length * M once the product is back.
						state_d  = S_INIT;
						mul_go   = 1'b1;
						mul_opnd = 64'(len_eff);
					end else begin
						do_mix = 1'b1;
						mix_h  = h_q;
					end
				end
			end
			S_INIT: begin
				if (mul_resp.done) begin
					do_mix = 1'b1;
					mix_h  = 64'(seed_q) ^ res;
				end
			end
			S_K1: begin
				if (mul_resp.done) begin
					state_d  = S_K2;
					mul_go   = 1'b1;
					mul_opnd = res_x;
				end
			end
			S_K2: begin
				if (mul_resp.done) begin
					state_d  = S_HMUL;
					mul_go   = 1'b1;
					mul_opnd = h_q ^ res;
				end
			end
			S_HMUL,
			S_TAIL: begin
				if (mul_resp.done) begin
					do_post = 1'b1;
					post_h  = res;
				end
			end
			S_FIN: begin
				if (mul_resp.done) begin
					state_d = S_OUT;
					h_d     = res_x;
				end
			end
			S_OUT: begin
				// Hold the finished hash until the output register is free.
				if (!hash_valid_q || hash_ready) begin
					out_load = 1'b1;
					cnt_d    = '0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Mix in the word: full word, partial tail, or nothing past the key end.
		if (do_mix) begin
			h_d = mix_h;
			if (full_sel) begin
				state_d  = S_K1;
				mul_go   = 1'b1;
				mul_opnd = word_sel;
			end else if (tmix_sel) begin
				state_d  = S_TAIL;
				mul_go   = 1'b1;
				mul_opnd = mix_h ^ (word_sel & tail_mask);
			end else begin
				do_post = 1'b1;
				post_h  = mix_h;
			end
		end

		// After mixing: finish on the last word, otherwise advance the count.
		if (do_post) begin
			h_d = post_h;
			if (last_sel) begin
				state_d  = S_FIN;
				mul_go   = 1'b1;
				mul_opnd = post_h ^ (post_h >> MIX_SHIFT);
			end else begin
				state_d = S_IDLE;
				cnt_d   = cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= '0;
			klen_q       <= '0;
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			mul_go_q     <= 1'b0;
			hash_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HASH_SEED:  seed_q <= cfg_wdata[SEED_W-1:0];
					REG_KEY_LENGTH: klen_q <= cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			mul_go_q     <= mul_go;
			if (out_load) begin
				hash_valid_q <= 1'b1;
			end else if (hash_ready) begin
				hash_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		h_q        <= h_d;
		mul_opnd_q <= mul_opnd;
		if (key_xfer) begin
			word_q <= key_word;
			full_q <= acc_full;
			tmix_q <= acc_tmix;
			last_q <= acc_last;
			tail_q <= tail_w;
		end
		if (out_load) begin
			hash_value_q <= h_q;
		end
	end

	assign mul_req.go      = mul_go_q;
	assign mul_req.operand = mul_opnd_q;

	mhm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.resp   (mul_resp)
	);

	assign hash_valid = hash_valid_q;
	assign hash_value = hash_value_q;

	// A product only comes back while the sequencer waits on it.
	`MHM_ASSERT_NOW(a_done_busy, clk, arst_n, mul_resp.done, state_q != S_IDLE && state_q != S_OUT, "multiplier result with no multiply outstanding")
	// Never issue a multiply onto a busy unit.
	`MHM_ASSERT_NOW(a_go_free, clk, arst_n, mul_go_q, !mul_resp.busy && !mul_resp.done, "multiply issued while unit busy")
	// Only load the output register when its previous result has gone.
	`MHM_ASSERT_NOW(a_out_free, clk, arst_n, out_load, !hash_valid_q || hash_ready, "output register overwritten")
	// A word taken mid-key never reloads the seed.
	`MHM_ASSERT_NEXT(a_no_reload, clk, arst_n, key_xfer && cnt_q != '0, state_q != S_INIT, "seed reload in the middle of a key")

endmodule
